### sv/tmdq_pkg.sv
// ----------------------------------------------------------------------------
// tmdq_pkg
// Shared constants, codes and control types of the timed message delay queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tmdq_pkg;

   // default sizes
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_HANDLE_BITS = 16;

   // fixed field widths
   localparam int COUNTDOWN_BITS    = 8;
   localparam int DIR_BITS          = 2;
   localparam int HANDLE_FIELD_BITS = 16;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;

   // latency register reset values
   localparam logic [COUNTDOWN_BITS-1:0] RESET_LAT_UPPER    = 8'd15;
   localparam logic [COUNTDOWN_BITS-1:0] RESET_LAT_TO_MEM   = 8'd5;
   localparam logic [COUNTDOWN_BITS-1:0] RESET_LAT_FROM_MEM = 8'd5;

   // register indexes
   localparam logic [1:0] REG_LAT_UPPER    = 2'd0;
   localparam logic [1:0] REG_LAT_TO_MEM   = 2'd1;
   localparam logic [1:0] REG_LAT_FROM_MEM = 2'd2;

   // item operation codes
   localparam logic OP_SEND = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kind codes
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_DROP    = 1'b1;

   // direction codes
   localparam logic [DIR_BITS-1:0] DIR_TO_UPPER = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_TO_MEM   = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_FROM_MEM = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_NONE     = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic store;        // append the request message at the tail
      logic drop;         // capture the request message as a drop result
      logic tick_start;   // rewind the walk pointers
      logic walk_en;      // walk the queue one entry per cycle unless held by the output
      logic walk_finish;  // commit the survivor count
      logic flush;        // move the pending result to the output with last set
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic walk_done;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### sv/tmdq_ctrl.sv
// ----------------------------------------------------------------------------
// tmdq_ctrl
// Controller: takes request transfers, sequences the tick walk and the
// final result of a dropped send or of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tmdq_ctrl
   import tmdq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_op,
   input  wire logic [DIR_BITS-1:0] req_direction,
   output logic                     req_stall,
   input  wire status_type          status,
   output cmd_type                  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   logic accept;
   logic dir_ok;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign dir_ok    = (req_direction != DIR_NONE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_TICK) begin
                  cmd.tick_start = 1'b1;
                  state_in       = ST_WALK;
               end else if (dir_ok) begin
                  if (status.full) begin
                     cmd.drop = 1'b1;
                     state_in = ST_FLUSH;
                  end else begin
                     cmd.store = 1'b1;
                  end
               end
            end
         end
         ST_WALK: begin
            cmd.walk_en = 1'b1;
            if (status.walk_done) begin
               cmd.walk_finish = 1'b1;
               state_in        = status.pend_valid ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/tmdq_dp.sv
// ----------------------------------------------------------------------------
// tmdq_dp
// Datapath: message memory, fill count, walk pointers, pending result and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmdq_dp
   import tmdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cmd_type                      cmd,
   output status_type                        status,
   input  wire logic [DIR_BITS-1:0]          req_direction,
   input  wire logic [HANDLE_FIELD_BITS-1:0] req_block_handle,
   input  wire logic [COUNTDOWN_BITS-1:0]    lat_upper,
   input  wire logic [COUNTDOWN_BITS-1:0]    lat_to_mem,
   input  wire logic [COUNTDOWN_BITS-1:0]    lat_from_mem,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_kind,
   output logic [DIR_BITS-1:0]               rsp_out_direction,
   output logic [HANDLE_FIELD_BITS-1:0]      rsp_out_block_handle,
   output logic                              rsp_last
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = COUNTDOWN_BITS + DIR_BITS + HANDLE_BITS;

   // message memory: countdown, direction, handle
   logic [EW-1:0] mem_ff [QUEUE_DEPTH];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] keep_ff, keep_in;

   logic          ev_valid_ff, ev_valid_in;
   logic [EW-1:0] ev_data_ff;

   logic                         pend_valid_ff, pend_valid_in;
   logic                         pend_kind_ff, pend_kind_in;
   logic [DIR_BITS-1:0]          pend_dir_ff, pend_dir_in;
   logic [HANDLE_FIELD_BITS-1:0] pend_handle_ff, pend_handle_in;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_kind_ff, out_kind_in;
   logic [DIR_BITS-1:0]          out_dir_ff, out_dir_in;
   logic [HANDLE_FIELD_BITS-1:0] out_handle_ff, out_handle_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_load;

   logic [COUNTDOWN_BITS-1:0] ev_cd;
   logic [DIR_BITS-1:0]       ev_dir;
   logic [HANDLE_BITS-1:0]    ev_handle;
   logic                      ev_expired;
   logic                      out_free;
   logic                      hold;
   logic                      advance;
   logic                      issue;
   logic                      eval;

   logic [COUNTDOWN_BITS-1:0] lat_sel;
   logic [COUNTDOWN_BITS-1:0] new_cd;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // fields of the entry under evaluation
   assign ev_cd      = ev_data_ff[EW-1 -: COUNTDOWN_BITS];
   assign ev_dir     = ev_data_ff[HANDLE_BITS +: DIR_BITS];
   assign ev_handle  = ev_data_ff[HANDLE_BITS-1:0];
   assign ev_expired = ev_valid_ff && (ev_cd == '0);

   // walk control: stall only when an expired entry must push out a pending one and the output is busy
   assign out_free = !out_valid_ff || !rsp_stall;
   assign hold     = ev_expired && pend_valid_ff && !out_free;
   assign advance  = cmd.walk_en && !hold;
   assign issue    = advance && (rd_ff != count_ff);
   assign eval     = advance && ev_valid_ff;

   // countdown of a new message from the latency register of its direction, decremented and floored at zero
   always_comb begin
      case (req_direction)
         DIR_TO_UPPER: lat_sel = lat_upper;
         DIR_TO_MEM:   lat_sel = lat_to_mem;
         default:      lat_sel = lat_from_mem;
      endcase
      new_cd = (lat_sel == '0) ? '0 : lat_sel - COUNTDOWN_BITS'(1);
   end

   // single memory write port: tail append or survivor compaction
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = {new_cd, req_direction, HANDLE_BITS'(req_block_handle)};
      if (cmd.store) begin
         wr_en = 1'b1;
      end else if (eval && !ev_expired) begin
         wr_en   = 1'b1;
         wr_addr = keep_ff[AW-1:0];
         wr_data = {ev_cd - COUNTDOWN_BITS'(1), ev_dir, ev_handle};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (issue) begin
         ev_data_ff <= mem_ff[rd_ff[AW-1:0]];
      end
   end

   // pointers, pending result and output register
   always_comb begin
      count_in       = count_ff;
      rd_in          = rd_ff;
      keep_in        = keep_ff;
      ev_valid_in    = ev_valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_dir_in    = pend_dir_ff;
      pend_handle_in = pend_handle_ff;
      out_load       = 1'b0;
      out_kind_in    = out_kind_ff;
      out_dir_in     = out_dir_ff;
      out_handle_in  = out_handle_ff;
      out_last_in    = out_last_ff;

      if (cmd.store) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.drop) begin
         pend_valid_in  = 1'b1;
         pend_kind_in   = KIND_DROP;
         pend_dir_in    = req_direction;
         pend_handle_in = req_block_handle;
      end

      if (cmd.tick_start) begin
         rd_in         = '0;
         keep_in       = '0;
         ev_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (advance) begin
         ev_valid_in = issue;
      end
      if (issue) begin
         rd_in = rd_ff + CW'(1);
      end

      if (eval) begin
         if (!ev_expired) begin
            keep_in = keep_ff + CW'(1);
         end else begin
            if (pend_valid_ff) begin
               out_load      = 1'b1;
               out_kind_in   = pend_kind_ff;
               out_dir_in    = pend_dir_ff;
               out_handle_in = pend_handle_ff;
               out_last_in   = 1'b0;
            end
            pend_valid_in  = 1'b1;
            pend_kind_in   = KIND_DELIVER;
            pend_dir_in    = ev_dir;
            pend_handle_in = HANDLE_FIELD_BITS'(ev_handle);
         end
      end

      if (cmd.walk_finish) begin
         count_in = keep_ff;
      end

      if (cmd.flush) begin
         out_load      = 1'b1;
         out_kind_in   = pend_kind_ff;
         out_dir_in    = pend_dir_ff;
         out_handle_in = pend_handle_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_ff         <= '0;
         keep_ff       <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rd_ff         <= rd_in;
         keep_ff       <= keep_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_kind_ff   <= pend_kind_in;
      pend_dir_ff    <= pend_dir_in;
      pend_handle_ff <= pend_handle_in;
      out_kind_ff    <= out_kind_in;
      out_dir_ff     <= out_dir_in;
      out_handle_ff  <= out_handle_in;
      out_last_ff    <= out_last_in;
   end

   // status to the controller
   assign status.full       = (count_ff == CW'(QUEUE_DEPTH));
   assign status.walk_done  = !ev_valid_ff && (rd_ff == count_ff);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid            = out_valid_ff;
   assign rsp_kind             = out_kind_ff;
   assign rsp_out_direction    = out_dir_ff;
   assign rsp_out_block_handle = out_handle_ff;
   assign rsp_last             = out_last_ff;

endmodule

`default_nettype wire

### sv/timed_message_delay_queue_top.sv
// Send: stored at the tail; a drop result is issued instead when the queue is full.
// Tick: one memory read per cycle while the walk is not held by a stalled result
// side, then a last evaluation and a commit, plus a flush of the final result
// when anything is delivered.
// Results leave through an output register, one per cycle at most.
// Reset (synchronous): queue empty, latencies 15, 5 and 5.
// ----------------------------------------------------------------------------
// timed_message_delay_queue_top
// Fixed-latency delay queue for cache messages with latency registers.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_message_delay_queue_top
   import tmdq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int HANDLE_BITS = DEFAULT_HANDLE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_op,
   input  wire logic [DIR_BITS-1:0]          req_direction,
   input  wire logic [HANDLE_FIELD_BITS-1:0] req_block_handle,
   // result channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_kind,
   output logic [DIR_BITS-1:0]               rsp_out_direction,
   output logic [HANDLE_FIELD_BITS-1:0]      rsp_out_block_handle,
   output logic                              rsp_last,
   // register port
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [CSR_DATA_BITS-1:0]     pwdata,
   output logic [CSR_DATA_BITS-1:0]          prdata,
   output logic                              pready
);

   logic [COUNTDOWN_BITS-1:0] lat_upper_ff, lat_upper_in;
   logic [COUNTDOWN_BITS-1:0] lat_to_mem_ff, lat_to_mem_in;
   logic [COUNTDOWN_BITS-1:0] lat_from_mem_ff, lat_from_mem_in;

   logic       csr_write;
   logic [1:0] csr_index;

   cmd_type    cmd;
   status_type status;

   // latency registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      lat_upper_in    = lat_upper_ff;
      lat_to_mem_in   = lat_to_mem_ff;
      lat_from_mem_in = lat_from_mem_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LAT_UPPER:    lat_upper_in    = pwdata[COUNTDOWN_BITS-1:0];
            REG_LAT_TO_MEM:   lat_to_mem_in   = pwdata[COUNTDOWN_BITS-1:0];
            REG_LAT_FROM_MEM: lat_from_mem_in = pwdata[COUNTDOWN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_upper_ff    <= RESET_LAT_UPPER;
         lat_to_mem_ff   <= RESET_LAT_TO_MEM;
         lat_from_mem_ff <= RESET_LAT_FROM_MEM;
      end else begin
         lat_upper_ff    <= lat_upper_in;
         lat_to_mem_ff   <= lat_to_mem_in;
         lat_from_mem_ff <= lat_from_mem_in;
      end
   end

   // register read back
   always_comb begin
      case (csr_index)
         REG_LAT_UPPER:    prdata = CSR_DATA_BITS'(lat_upper_ff);
         REG_LAT_TO_MEM:   prdata = CSR_DATA_BITS'(lat_to_mem_ff);
         REG_LAT_FROM_MEM: prdata = CSR_DATA_BITS'(lat_from_mem_ff);
         default:          prdata = '0;
      endcase
   end

   tmdq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_op        (req_op),
      .req_direction (req_direction),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   tmdq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_direction        (req_direction),
      .req_block_handle     (req_block_handle),
      .lat_upper            (lat_upper_ff),
      .lat_to_mem           (lat_to_mem_ff),
      .lat_from_mem         (lat_from_mem_ff),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_out_direction    (rsp_out_direction),
      .rsp_out_block_handle (rsp_out_block_handle),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire
